>>> sv/dce_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the digit cross-fade engine
// used by dce_ctrl, dce_dp and digit_crossfade_engine; depends on nothing
package dce_pkg;

	localparam int DIGIT_COUNT = 8;

	localparam int POS_W     = 3;
	localparam int DIGIT_W   = 4;
	localparam int TIME_W    = 48;
	localparam int LEVEL_W   = 8;
	localparam int FADE_MS_W = 16;

	// fade length in microseconds: 65535 * 1000 fits in 26 bits
	localparam int US_PER_MS = 1000;
	localparam int FADE_US_W = 26;

	// percent and divider sizing: elapsed * 100 with elapsed below the fade length
	localparam int PCT_FULL  = 100;
	localparam int PCT_W     = 7;
	localparam int NUM_W     = FADE_US_W + PCT_W;
	localparam int DIV_STEPS = PCT_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	// level * percent, then divide by 100 as (x * 5243) >> 19, exact for x below 43699
	localparam int PROD_W      = LEVEL_W + PCT_W;
	localparam int RECIP_100   = 5243;
	localparam int RECIP_W     = 13;
	localparam int RECIP_SHIFT = 19;
	localparam int SCALE_W     = PROD_W + RECIP_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_CMP,
		ST_DIV,
		ST_MUL,
		ST_NORM,
		ST_OUT
	} dce_state_t;

	typedef struct packed {
		logic cap;
		logic eval;
		logic cmp;
		logic div_step;
		logic mul;
		logic norm;
		logic out_load;
	} dce_cmd_t;

	typedef struct packed {
		logic pos_ok;
		logic run;
	} dce_status_t;

endpackage

>>> sv/dce_dp.sv
`timescale 1ns / 1ps
// datapath: fade length register, per-position digit state, restoring percent
// divider, level scaling and the result register; depends on dce_pkg
module dce_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [dce_pkg::FADE_MS_W-1:0]  cfg_wr_data,
	input  dce_pkg::dce_cmd_t              cmd,
	output dce_pkg::dce_status_t           status,
	input  logic [dce_pkg::POS_W-1:0]      position,
	input  logic [dce_pkg::DIGIT_W-1:0]    wanted_digit,
	input  logic [dce_pkg::TIME_W-1:0]     time_now_us,
	input  logic [dce_pkg::LEVEL_W-1:0]    level,
	output logic                           outgoing_shown,
	output logic [dce_pkg::DIGIT_W-1:0]    outgoing_digit,
	output logic [dce_pkg::LEVEL_W-1:0]    outgoing_level,
	output logic [dce_pkg::DIGIT_W-1:0]    incoming_digit,
	output logic [dce_pkg::LEVEL_W-1:0]    incoming_level
);
	import dce_pkg::*;

	logic [FADE_MS_W-1:0] fade_ms_q;

	// captured transaction
	logic [POS_W-1:0]   pos_q;
	logic [DIGIT_W-1:0] want_q;
	logic [TIME_W-1:0]  now_q;
	logic [LEVEL_W-1:0] level_q;

	// per-position state
	logic [DIGIT_W-1:0] old_digit_q [DIGIT_COUNT];
	logic               old_valid_q [DIGIT_COUNT];
	logic [DIGIT_W-1:0] new_digit_q [DIGIT_COUNT];
	logic               new_valid_q [DIGIT_COUNT];
	logic [TIME_W-1:0]  begin_us_q  [DIGIT_COUNT];
	logic               fading_q    [DIGIT_COUNT];

	// evaluation results
	logic                 pos_ok_q;
	logic                 fade_act_q;
	logic [DIGIT_W-1:0]   old_sel_q;
	logic [TIME_W-1:0]    elapsed_q;
	logic [FADE_US_W-1:0] fade_us_q;
	logic                 run_q;

	// divider
	logic [NUM_W-1:0] rem_q;
	logic [NUM_W-1:0] dsh_q;
	logic [PCT_W-1:0] quo_q;

	// scaling
	logic [PROD_W-1:0]  prod_in_q;
	logic [PROD_W-1:0]  prod_out_q;
	logic [SCALE_W-1:0] scale_in_q;
	logic [SCALE_W-1:0] scale_out_q;

	// result register
	logic               shown_q;
	logic [DIGIT_W-1:0] out_digit_q;
	logic [LEVEL_W-1:0] out_level_q;
	logic [DIGIT_W-1:0] in_digit_q;
	logic [LEVEL_W-1:0] in_level_q;

	logic               pos_ok;
	logic               changed;
	logic [DIGIT_W-1:0] old_digit_nx;
	logic               old_valid_nx;
	logic [TIME_W-1:0]  begin_nx;
	logic               fading_nx;
	logic [TIME_W-1:0]  elapsed_nx;
	logic               run;
	logic               div_ge;

	assign pos_ok = (int'(pos_q) < DIGIT_COUNT);

	always_comb begin
		changed      = !new_valid_q[pos_q] || (new_digit_q[pos_q] != want_q);
		old_digit_nx = changed ? new_digit_q[pos_q] : old_digit_q[pos_q];
		old_valid_nx = changed ? new_valid_q[pos_q] : old_valid_q[pos_q];
		begin_nx     = changed ? now_q : begin_us_q[pos_q];
		fading_nx    = changed ? (fade_ms_q != '0) : fading_q[pos_q];
		// a time before the stored start counts as no time gone by
		elapsed_nx   = (now_q >= begin_nx) ? (now_q - begin_nx) : '0;
	end

	assign run    = pos_ok_q && fade_act_q && (elapsed_q < TIME_W'(fade_us_q));
	assign div_ge = (rem_q >= dsh_q);

	assign status.pos_ok = pos_ok_q;
	assign status.run    = run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_ms_q <= '0;
		end else if (cfg_wr_en) begin
			fade_ms_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGIT_COUNT; i++) begin
				old_digit_q[i] <= '0;
				old_valid_q[i] <= 1'b0;
				new_digit_q[i] <= '0;
				new_valid_q[i] <= 1'b0;
				begin_us_q[i]  <= '0;
				fading_q[i]    <= 1'b0;
			end
		end else begin
			if (cmd.eval && pos_ok) begin
				old_digit_q[pos_q] <= old_digit_nx;
				old_valid_q[pos_q] <= old_valid_nx;
				new_digit_q[pos_q] <= want_q;
				new_valid_q[pos_q] <= 1'b1;
				begin_us_q[pos_q]  <= begin_nx;
				fading_q[pos_q]    <= fading_nx;
			end
			// fade over, no earlier digit or no fade: stop fading
			if (cmd.cmp && pos_ok_q && !run) begin
				fading_q[pos_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			pos_q   <= position;
			want_q  <= wanted_digit;
			now_q   <= time_now_us;
			level_q <= level;
		end
		if (cmd.eval) begin
			pos_ok_q   <= pos_ok;
			fade_act_q <= fading_nx && old_valid_nx;
			old_sel_q  <= old_digit_nx;
			elapsed_q  <= elapsed_nx;
			fade_us_q  <= FADE_US_W'(FADE_US_W'(fade_ms_q) * FADE_US_W'(US_PER_MS));
		end
		if (cmd.cmp) begin
			run_q <= run;
			rem_q <= NUM_W'(elapsed_q[FADE_US_W-1:0]) * NUM_W'(PCT_FULL);
			dsh_q <= NUM_W'(fade_us_q) << (DIV_STEPS - 1);
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			if (div_ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[PCT_W-2:0], div_ge};
			dsh_q <= dsh_q >> 1;
		end
		if (cmd.mul) begin
			prod_in_q  <= PROD_W'(level_q) * PROD_W'(quo_q);
			prod_out_q <= PROD_W'(level_q) * (PROD_W'(PCT_FULL) - PROD_W'(quo_q));
		end
		if (cmd.norm) begin
			scale_in_q  <= SCALE_W'(prod_in_q) * SCALE_W'(RECIP_100);
			scale_out_q <= SCALE_W'(prod_out_q) * SCALE_W'(RECIP_100);
		end
		if (cmd.out_load) begin
			if (!pos_ok_q) begin
				shown_q     <= 1'b0;
				out_digit_q <= '0;
				out_level_q <= '0;
				in_digit_q  <= '0;
				in_level_q  <= '0;
			end else if (run_q) begin
				shown_q     <= 1'b1;
				out_digit_q <= old_sel_q;
				out_level_q <= scale_out_q[RECIP_SHIFT +: LEVEL_W];
				in_digit_q  <= want_q;
				in_level_q  <= scale_in_q[RECIP_SHIFT +: LEVEL_W];
			end else begin
				shown_q     <= 1'b0;
				out_digit_q <= '0;
				out_level_q <= '0;
				in_digit_q  <= want_q;
				in_level_q  <= level_q;
			end
		end
	end

	assign outgoing_shown = shown_q;
	assign outgoing_digit = out_digit_q;
	assign outgoing_level = out_level_q;
	assign incoming_digit = in_digit_q;
	assign incoming_level = in_level_q;

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul |-> (quo_q < PCT_W'(PCT_FULL)))
		else $error("fade percent out of range");

	a_level_split: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && pos_ok_q && run_q) |=>
		(({1'b0, out_level_q} + {1'b0, in_level_q}) <= {1'b0, level_q}))
		else $error("fade levels exceed full level");

endmodule

>>> sv/dce_ctrl.sv
`timescale 1ns / 1ps
// controller: sequences capture, state update, percent division, scaling and
// the result handshake; depends on dce_pkg
module dce_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  logic                  out_stall,
	input  dce_pkg::dce_status_t  status,
	output dce_pkg::dce_cmd_t     cmd
);
	import dce_pkg::*;

	dce_state_t       state_q;
	dce_state_t       state_nx;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.cmp) begin
				cnt_q <= CNT_W'(DIV_STEPS - 1);
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.cap  = 1'b1;
					state_nx = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_nx = ST_CMP;
			end
			ST_CMP: begin
				cmd.cmp  = 1'b1;
				state_nx = status.run ? ST_DIV : ST_OUT;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0) begin
					state_nx = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul  = 1'b1;
				state_nx = ST_NORM;
			end
			ST_NORM: begin
				cmd.norm = 1'b1;
				state_nx = ST_OUT;
			end
			ST_OUT: begin
				// wait until the result register is free or being taken
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	a_accept_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_EVAL))
		else $error("accepted transaction not evaluated");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("pending result overwritten");

	a_valid_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result raised outside output state");

endmodule

>>> sv/digit_crossfade_engine.sv
`timescale 1ns / 1ps
// top level of the digit cross-fade engine: controller plus datapath
// depends on dce_pkg, dce_ctrl and dce_dp
//
// One transaction in gives one transaction out. An item is taken only while the
// engine is free: a position that starts or keeps a running fade holds the input
// stalled after acceptance through state update, compare, seven steps of the
// restoring percent divider (making this path the longer), scaling and the
// result load; any other item, through state update, compare and the load. The
// finished result waits in its own register, so the next item may be taken
// while it is still stalled; a new result waits only if the previous one has
// not yet been taken. The user must write fade_length_ms by cfg_wr_en /
// cfg_wr_data only while the engine is idle; the block does not enforce it.
module digit_crossfade_engine (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [dce_pkg::FADE_MS_W-1:0]  cfg_wr_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [dce_pkg::POS_W-1:0]      position,
	input  logic [dce_pkg::DIGIT_W-1:0]    wanted_digit,
	input  logic [dce_pkg::TIME_W-1:0]     time_now_us,
	input  logic [dce_pkg::LEVEL_W-1:0]    level,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           outgoing_shown,
	output logic [dce_pkg::DIGIT_W-1:0]    outgoing_digit,
	output logic [dce_pkg::LEVEL_W-1:0]    outgoing_level,
	output logic [dce_pkg::DIGIT_W-1:0]    incoming_digit,
	output logic [dce_pkg::LEVEL_W-1:0]    incoming_level
);
	import dce_pkg::*;

	dce_cmd_t    cmd;
	dce_status_t status;

	dce_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	dce_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.cmd            (cmd),
		.status         (status),
		.position       (position),
		.wanted_digit   (wanted_digit),
		.time_now_us    (time_now_us),
		.level          (level),
		.outgoing_shown (outgoing_shown),
		.outgoing_digit (outgoing_digit),
		.outgoing_level (outgoing_level),
		.incoming_digit (incoming_digit),
		.incoming_level (incoming_level)
	);

endmodule
